### rtl/text_console_with_scrollback_unit_macros.svh
// Assertion macros for the console engine
`ifndef TEXT_CONSOLE_WITH_SCROLLBACK_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WITH_SCROLLBACK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TCSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("console invariant failed");
`define TCSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console implication failed");
`else
`define TCSU_ASSERT(lbl, clk, rst_n, prop)
`define TCSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/tcsu_pkg.sv
package tcsu_pkg;

    localparam int ROWS          = 25;
    localparam int COLS          = 80;
    localparam int HISTORY_LINES = 256;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CNT_W   = 9;
    localparam int SLOT_W  = CNT_W + 1;
    localparam int WL_W    = $clog2(HISTORY_LINES);
    localparam int CELLS   = ROWS * COLS;
    localparam int SCR_AW  = $clog2(CELLS);
    localparam int SB_AW   = $clog2(HISTORY_LINES * COLS);
    localparam int SC_W    = $clog2(COLS + 1);
    localparam int STEP    = ROWS - 1;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;

    localparam logic [2:0] MODE_PUT   = 3'd0;
    localparam logic [2:0] MODE_CLEAR = 3'd1;
    localparam logic [2:0] MODE_UP    = 3'd2;
    localparam logic [2:0] MODE_DOWN  = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [3:0] K_PRINT = 4'd0;
    localparam logic [3:0] K_NL    = 4'd1;
    localparam logic [3:0] K_CR    = 4'd2;
    localparam logic [3:0] K_BS    = 4'd3;
    localparam logic [3:0] K_TAB   = 4'd4;
    localparam logic [3:0] K_CLEAR = 4'd5;
    localparam logic [3:0] K_UP    = 4'd6;
    localparam logic [3:0] K_DOWN  = 4'd7;
    localparam logic [3:0] K_READ  = 4'd8;
    localparam logic [3:0] K_NOP   = 4'd9;

    typedef struct packed {
        logic [3:0]       kind;
        logic [7:0]       ch;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_t;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] r);
        logic [ROW_W:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= (ROW_W+1)'(ROWS))
            s = s - (ROW_W+1)'(ROWS);
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [SCR_AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return SCR_AW'(r) * SCR_AW'(COLS) + SCR_AW'(c);
    endfunction

    function automatic logic [SB_AW-1:0] sb_addr(input logic [WL_W-1:0] l,
                                                 input logic [COL_W-1:0] c);
        return SB_AW'(l) * SB_AW'(COLS) + SB_AW'(c);
    endfunction

endpackage

### rtl/text_console_with_scrollback_unit.sv
// Put, paging and no-op items go from idle to the emit state, an in-range cell
// read via the read state; a put that scrolls sweeps the top row in the scroll
// state and a clear the whole screen in the clear state, one cell a cycle over
// the screen memory port. The back end takes one item at a time and pops only
// while its output register has room. Reset: rst_n is asynchronous; after
// release a pass blanks the screen memory, during which the back end takes no
// item and the front queue accepts at most two. Scrollback is not cleared.
module text_console_with_scrollback_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,   // text_attribute
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // char_byte[7:0], read_row[12:8], read_col[19:13]
    input  logic [2:0]  s_tuser,    // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_char[7:0], cell_attr[15:8], cursor_line[20:16], cursor_column[27:21],
    // view_back_lines[36:28], stored_lines[45:37]
    output logic [47:0] m_tdata
);
    import tcsu_pkg::*;

    // front end decodes each item into an operation and queues two deep;
    // back end owns the screen ring, history ring and cursor state
    q_t   q;
    logic pop;

    tcsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .q        (q)
    );

    // screen rows live in a ring: scrolling moves the top-row pointer,
    // copies the old top row to history and blanks it in the same sweep
    tcsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q        (q),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/tcsu_front.sv
module tcsu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,  // char_byte[7:0], read_row[12:8], read_col[19:13]
    input  logic [2:0]        s_tuser,  // mode[2:0]
    input  logic              pop,
    output tcsu_pkg::q_t      q
);
    import tcsu_pkg::*;

    op_t        ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    op_t        dec;
    logic       push, take;

    always_comb
    begin
        dec.ch  = s_tdata[7:0];
        dec.row = s_tdata[12:8];
        dec.col = s_tdata[19:13];
        case (s_tuser)
            MODE_PUT:
            begin
                case (s_tdata[7:0])
                    CH_NL:   dec.kind = K_NL;
                    CH_CR:   dec.kind = K_CR;
                    CH_BS:   dec.kind = K_BS;
                    CH_TAB:  dec.kind = K_TAB;
                    default: dec.kind = K_PRINT;
                endcase
            end
            MODE_CLEAR: dec.kind = K_CLEAR;
            MODE_UP:    dec.kind = K_UP;
            MODE_DOWN:  dec.kind = K_DOWN;
            MODE_READ:  dec.kind = K_READ;
            default:    dec.kind = K_NOP;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign take     = pop && (cnt_reg != 2'd0);
    assign q.valid  = (cnt_reg != 2'd0);
    assign q.op     = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (take)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(take);
        end
    end

endmodule

### rtl/tcsu_back.sv
`include "text_console_with_scrollback_unit_macros.svh"
module tcsu_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_data,
    input  tcsu_pkg::q_t q,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata
);
    import tcsu_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;

    logic [15:0] scr_mem [CELLS];
    logic [15:0] sb_mem  [HISTORY_LINES * COLS];

    logic [2:0]        state_reg, state_next;
    logic [7:0]        attr_reg;
    logic [ROW_W-1:0]  cy_reg, cy_next, top_reg, top_next;
    logic [COL_W-1:0]  cx_reg, cx_next;
    logic [CNT_W-1:0]  vb_reg, vb_next, fill_reg, fill_next;
    logic [WL_W-1:0]   wl_reg, wl_next;
    logic [SC_W-1:0]   sc_reg, sc_next;
    logic [SCR_AW-1:0] clr_reg, clr_next;
    logic              src_reg, src_next;
    logic              out_valid_reg, out_valid_next;
    logic [47:0]       out_data_reg, out_data_next;

    logic              scr_we, sb_we;
    logic [SCR_AW-1:0] scr_wa, scr_ra;
    logic [SB_AW-1:0]  sb_wa, sb_ra;
    logic [15:0]       scr_wd, sb_wd, scr_rd_reg, sb_rd_reg, rd_cell;

    logic [COL_W:0]    cx_inc, cx_tab;
    logic [CNT_W:0]    vb_up;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  sc_col, sc_prev;
    logic              nl, can_pop;

    assign can_pop = !out_valid_reg || m_tready;
    assign pop     = (state_reg == S_IDLE) && q.valid && can_pop;
    assign cx_inc  = {1'b0, cx_reg} + (COL_W+1)'(1);
    assign cx_tab  = ({1'b0, cx_reg} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
    assign vb_up   = {1'b0, vb_reg} + (CNT_W+1)'(STEP);
    assign slot    = SLOT_W'(wl_reg) + SLOT_W'(HISTORY_LINES) - SLOT_W'(vb_reg)
                     + SLOT_W'(q.op.row);
    assign sc_col  = sc_reg[COL_W-1:0];
    assign sc_prev = sc_col - COL_W'(1);
    assign rd_cell = src_reg ? sb_rd_reg : scr_rd_reg;

    always_comb
    begin
        state_next     = state_reg;
        cy_next        = cy_reg;
        cx_next        = cx_reg;
        top_next       = top_reg;
        vb_next        = vb_reg;
        fill_next      = fill_reg;
        wl_next        = wl_reg;
        sc_next        = sc_reg;
        clr_next       = clr_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        scr_we = 1'b0;
        scr_wa = '0;
        scr_wd = {attr_reg, CH_SPACE};
        scr_ra = '0;
        sb_we  = 1'b0;
        sb_wa  = '0;
        sb_wd  = scr_rd_reg;
        sb_ra  = '0;
        nl     = 1'b0;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                scr_we = 1'b1;
                scr_wa = clr_reg;
                if (state_reg == S_INIT)
                    scr_wd = {ATTR_RESET, CH_SPACE};
                clr_next = clr_reg + SCR_AW'(1);
                if (clr_reg == SCR_AW'(CELLS - 1))
                begin
                    clr_next   = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_EMIT;
                end
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_EMIT;
                    case (q.op.kind)
                        K_PRINT:
                        begin
                            vb_next = '0;
                            scr_we  = 1'b1;
                            scr_wa  = cell_addr(phys_row(top_reg, cy_reg), cx_reg);
                            scr_wd  = {attr_reg, q.op.ch};
                            if (cx_inc >= (COL_W+1)'(COLS))
                                nl = 1'b1;
                            else
                                cx_next = cx_inc[COL_W-1:0];
                        end
                        K_NL:
                        begin
                            vb_next = '0;
                            nl      = 1'b1;
                        end
                        K_CR:
                        begin
                            vb_next = '0;
                            cx_next = '0;
                        end
                        K_BS:
                        begin
                            vb_next = '0;
                            if (cx_reg != '0)
                            begin
                                cx_next = cx_reg - COL_W'(1);
                                scr_we  = 1'b1;
                                scr_wa  = cell_addr(phys_row(top_reg, cy_reg),
                                                    cx_reg - COL_W'(1));
                            end
                        end
                        K_TAB:
                        begin
                            vb_next = '0;
                            if (cx_tab >= (COL_W+1)'(COLS))
                                nl = 1'b1;
                            else
                                cx_next = cx_tab[COL_W-1:0];
                        end
                        K_CLEAR:
                        begin
                            cy_next    = '0;
                            cx_next    = '0;
                            vb_next    = '0;
                            top_next   = '0;
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        K_UP:
                        begin
                            if (vb_up <= {1'b0, fill_reg})
                                vb_next = vb_up[CNT_W-1:0];
                            else
                                vb_next = fill_reg;
                        end
                        K_DOWN:
                        begin
                            if (vb_reg > CNT_W'(STEP))
                                vb_next = vb_reg - CNT_W'(STEP);
                            else
                                vb_next = '0;
                        end
                        K_READ:
                        begin
                            if (q.op.row >= ROW_W'(ROWS) || q.op.col >= COL_W'(COLS))
                                state_next = S_EMIT;
                            else if (CNT_W'(q.op.row) >= vb_reg)
                            begin
                                scr_ra = cell_addr(phys_row(top_reg,
                                             q.op.row - vb_reg[ROW_W-1:0]), q.op.col);
                                src_next   = 1'b0;
                                state_next = S_READ;
                            end
                            else
                            begin
                                if (slot >= SLOT_W'(HISTORY_LINES))
                                    sb_ra = sb_addr(WL_W'(slot - SLOT_W'(HISTORY_LINES)),
                                                    q.op.col);
                                else
                                    sb_ra = sb_addr(slot[WL_W-1:0], q.op.col);
                                src_next   = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (nl)
                    begin
                        cx_next = '0;
                        if (cy_reg == ROW_W'(ROWS - 1))
                        begin
                            sc_next    = '0;
                            state_next = S_SCROLL;
                        end
                        else
                            cy_next = cy_reg + ROW_W'(1);
                    end
                end
            end
            S_SCROLL:
            begin
                // read top row cell c, copy cell c-1 to history and blank it
                if (sc_reg < SC_W'(COLS))
                    scr_ra = cell_addr(top_reg, sc_col);
                if (sc_reg != '0)
                begin
                    sb_we  = 1'b1;
                    sb_wa  = sb_addr(wl_reg, sc_prev);
                    scr_we = 1'b1;
                    scr_wa = cell_addr(top_reg, sc_prev);
                end
                sc_next = sc_reg + SC_W'(1);
                if (sc_reg == SC_W'(COLS))
                begin
                    wl_next  = (wl_reg == WL_W'(HISTORY_LINES - 1)) ? '0
                               : wl_reg + WL_W'(1);
                    if (fill_reg < CNT_W'(HISTORY_LINES))
                        fill_next = fill_reg + CNT_W'(1);
                    top_next = phys_row(top_reg, ROW_W'(1));
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {2'b00, fill_reg, vb_reg, cx_reg, cy_reg, 16'h0000};
                state_next     = S_IDLE;
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {2'b00, fill_reg, vb_reg, cx_reg, cy_reg,
                                  rd_cell[15:8], rd_cell[7:0]};
                state_next     = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[scr_wa] <= scr_wd;
        scr_rd_reg <= scr_mem[scr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sb_we)
            sb_mem[sb_wa] <= sb_wd;
        sb_rd_reg <= sb_mem[sb_ra];
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            attr_reg      <= ATTR_RESET;
            cy_reg        <= '0;
            cx_reg        <= '0;
            top_reg       <= '0;
            vb_reg        <= '0;
            fill_reg      <= '0;
            wl_reg        <= '0;
            sc_reg        <= '0;
            clr_reg       <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                attr_reg  <= cfg_data;
            cy_reg        <= cy_next;
            cx_reg        <= cx_next;
            top_reg       <= top_next;
            vb_reg        <= vb_next;
            fill_reg      <= fill_next;
            wl_reg        <= wl_next;
            sc_reg        <= sc_next;
            clr_reg       <= clr_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `TCSU_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= CNT_W'(HISTORY_LINES))
    `TCSU_ASSERT(a_view_bound, clk, rst_n, vb_reg <= fill_reg)
    `TCSU_ASSERT(a_cursor_bound, clk, rst_n, cy_reg < ROW_W'(ROWS) && cx_reg < COL_W'(COLS))
    `TCSU_ASSERT_IMP(a_scroll_row, clk, rst_n, state_reg == S_SCROLL, cy_reg == ROW_W'(ROWS - 1) && !out_valid_reg)

endmodule
